// File: rtl/bgpm_pkg.sv
// Package: shared constants, discharge-curve table, command and status types.
package bgpm_pkg;

  localparam int TABLE_DEPTH_DEF = 179;
  localparam int ADC_BITS_DEF    = 12;
  localparam int CURVE_LEN       = 179;
  localparam longint VREF_UV     = 64'd3300000;
  localparam int PCT_W           = 7;
  localparam int CFG_IDX_W       = 2;
  localparam int CFG_DATA_W      = 7;
  localparam int FULL_IDX        = 6;
  localparam int EMPTY_IDX       = 135;
  localparam int PCT_SPAN        = 129;

  localparam logic [CFG_IDX_W-1:0] REG_LOW_PCT  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CRIT_PCT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DIM_BL   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_FULL_BL  = 2'd3;

  localparam logic [PCT_W-1:0] LOW_PCT_RST  = 7'd15;
  localparam logic [PCT_W-1:0] CRIT_PCT_RST = 7'd5;
  localparam logic [PCT_W-1:0] DIM_BL_RST   = 7'd50;
  localparam logic [PCT_W-1:0] FULL_BL_RST  = 7'd100;

  typedef enum logic [1:0] {
    MODE_NORMAL = 2'd0,
    MODE_LOW    = 2'd1,
    MODE_RLOW   = 2'd2
  } batt_mode_t;

  typedef enum logic [1:0] {
    DISP_NONE = 2'd0,
    DISP_OFF  = 2'd1,
    DISP_ON   = 2'd2
  } disp_cmd_t;

  typedef enum logic [1:0] {
    SW_NONE = 2'd0,
    SW_STOP = 2'd1,
    SW_RUN  = 2'd2
  } sw_cmd_t;

  typedef struct packed {
    logic load;
    logic step;
    logic calc;
    logic commit;
  } dp_cmd_t;

  typedef struct packed {
    logic search_done;
  } dp_stat_t;

  localparam int unsigned CURVE_UV [CURVE_LEN] = '{
    3293315, 3292731, 3123113, 3104920, 3091277, 3080046, 3070496, 3061957,
    3054446, 3047753, 3041513, 3035591, 3030233, 3025011, 3020161, 3015326,
    3010809, 3006468, 3002290, 2998205, 2994119, 2990301, 2986596, 2982802,
    2978996, 2975205, 2971621, 2967781, 2964034, 2960522, 2956823, 2953116,
    2949739, 2946137, 2942633, 2939361, 2935978, 2932665, 2929420, 2926419,
    2923369, 2920036, 2917194, 2913765, 2910908, 2907679, 2904595, 2901674,
    2898639, 2895526, 2892602, 2889694, 2886763, 2883809, 2881005, 2878070,
    2875451, 2872488, 2869685, 2866886, 2864358, 2861631, 2858793, 2856131,
    2853451, 2851026, 2848224, 2845529, 2843077, 2840410, 2837907, 2835312,
    2832920, 2830289, 2827673, 2825246, 2823085, 2820487, 2818084, 2815562,
    2813238, 2810697, 2808433, 2806010, 2803995, 2801507, 2799182, 2796974,
    2794702, 2792408, 2790227, 2788119, 2785990, 2783873, 2781659, 2779387,
    2777647, 2775543, 2773495, 2771644, 2769655, 2767760, 2765803, 2764118,
    2762089, 2760437, 2758753, 2756918, 2755414, 2753702, 2752189, 2750504,
    2749089, 2747258, 2745884, 2744224, 2742853, 2741238, 2739683, 2738211,
    2736779, 2735069, 2733758, 2732096, 2730601, 2729134, 2727362, 2725767,
    2724196, 2722577, 2721084, 2719173, 2717416, 2715724, 2713717, 2711964,
    2710198, 2708288, 2706265, 2704319, 2702024, 2699998, 2697884, 2695704,
    2693288, 2690949, 2688524, 2686158, 2683574, 2680681, 2677945, 2674853,
    2671614, 2668388, 2664996, 2661252, 2657310, 2653002, 2648212, 2642976,
    2637527, 2631104, 2623964, 2616142, 2607163, 2596740, 2585297, 2572205,
    2557120, 2540295, 2520790, 2498541, 2472818, 2443045, 2408514, 2367405,
    2317233, 2251871, 2166412
  };

  // ADC-code threshold: code > thr  <=>  code*VREF > t*full
  function automatic longint thr_of(input int idx, input int bits);
    longint full;
    full = (longint'(1) << bits) - 1;
    return (longint'(CURVE_UV[idx]) * full) / VREF_UV;
  endfunction

  function automatic logic [PCT_W-1:0] pct_of(input int idx);
    int p;
    if (idx <= FULL_IDX) p = 100;
    else if (idx >= EMPTY_IDX) p = 0;
    else p = 99 - ((idx - FULL_IDX) * 100) / PCT_SPAN;
    return PCT_W'(p);
  endfunction

endpackage

// File: rtl/bgpm_in_if.sv
// Interface: battery sample channel.
interface bgpm_in_if #(
  parameter int ADC_BITS = 12
);
  logic                valid;
  logic                ready;
  logic [ADC_BITS-1:0] adc_code;

  modport source (output valid, output adc_code, input ready);
  modport sink   (input valid, input adc_code, output ready);
endinterface

// Interface: gauge result channel.
interface bgpm_out_if;
  logic       valid;
  logic       ready;
  logic [6:0] percent;
  logic [1:0] battery_mode;
  logic [1:0] display_cmd;
  logic [1:0] stopwatch_cmd;
  logic       backlight_set;
  logic [6:0] backlight_level;
  logic       supply_on;

  modport source (output valid, output percent, output battery_mode, output display_cmd,
                  output stopwatch_cmd, output backlight_set, output backlight_level,
                  output supply_on, input ready);
  modport sink   (input valid, input percent, input battery_mode, input display_cmd,
                  input stopwatch_cmd, input backlight_set, input backlight_level,
                  input supply_on, output ready);
endinterface

// File: rtl/bgpm_datapath.sv
// Datapath: config registers, binary search over thresholds, percent, power manager.
module bgpm_datapath import bgpm_pkg::*; #(
  parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
  parameter int ADC_BITS    = ADC_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic [ADC_BITS-1:0]   adc_code,
  input  dp_cmd_t               cmd,
  output dp_stat_t              stat,
  output logic [PCT_W-1:0]      percent,
  output logic [1:0]            battery_mode,
  output logic [1:0]            display_cmd,
  output logic [1:0]            stopwatch_cmd,
  output logic                  backlight_set,
  output logic [PCT_W-1:0]      backlight_level,
  output logic                  supply_on
);

  localparam int SEARCH_N = (TABLE_DEPTH < CURVE_LEN) ? TABLE_DEPTH : CURVE_LEN;
  localparam int IDX_W    = $clog2(TABLE_DEPTH + 1);
  localparam int SIDX_W   = $clog2(SEARCH_N);

  logic [ADC_BITS-1:0] thr     [SEARCH_N];
  logic [PCT_W-1:0]    pct_tab [SEARCH_N+1];

  for (genvar g = 0; g < SEARCH_N; g++) begin : g_thr
    assign thr[g] = ADC_BITS'(thr_of(g, ADC_BITS));
  end
  for (genvar g = 0; g <= SEARCH_N; g++) begin : g_pct
    assign pct_tab[g] = pct_of(g);
  end

  logic [ADC_BITS-1:0] code;
  logic [IDX_W-1:0]    lo;
  logic [IDX_W-1:0]    hi;
  logic [PCT_W-1:0]    pct;
  batt_mode_t          mode;
  logic                supply;
  logic [PCT_W-1:0]    low_pct;
  logic [PCT_W-1:0]    crit_pct;
  logic [PCT_W-1:0]    dim_bl;
  logic [PCT_W-1:0]    full_bl;

  logic [IDX_W:0]   mid_sum;
  logic [IDX_W-1:0] mid;
  logic             exceeded;

  batt_mode_t       mode_next;
  logic             supply_next;
  disp_cmd_t        disp_next;
  sw_cmd_t          sw_next;
  logic             bl_set_next;
  logic [PCT_W-1:0] bl_level_next;

  assign mid_sum  = {1'b0, lo} + {1'b0, hi};
  assign mid      = mid_sum[IDX_W:1];
  assign exceeded = code > thr[mid[SIDX_W-1:0]];
  assign stat.search_done = (lo == hi);

  always_ff @(posedge clk) begin
    if (rst) begin
      low_pct  <= LOW_PCT_RST;
      crit_pct <= CRIT_PCT_RST;
      dim_bl   <= DIM_BL_RST;
      full_bl  <= FULL_BL_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_LOW_PCT:  low_pct  <= cfg_data;
        REG_CRIT_PCT: crit_pct <= cfg_data;
        REG_DIM_BL:   dim_bl   <= cfg_data;
        REG_FULL_BL:  full_bl  <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      code <= adc_code;
      lo   <= '0;
      hi   <= IDX_W'(SEARCH_N);
    end else if (cmd.step) begin
      if (exceeded) hi <= mid;
      else lo <= mid + IDX_W'(1);
    end
    if (cmd.calc) pct <= pct_tab[lo];
  end

  always_comb begin
    mode_next     = mode;
    supply_next   = supply;
    disp_next     = DISP_NONE;
    sw_next       = SW_NONE;
    bl_set_next   = 1'b0;
    bl_level_next = '0;
    if (pct == '0) begin
      disp_next   = DISP_OFF;
      supply_next = 1'b0;
    end else if (pct <= crit_pct) begin
      disp_next     = DISP_OFF;
      bl_set_next   = 1'b1;
      bl_level_next = dim_bl;
      sw_next       = SW_STOP;
      mode_next     = MODE_RLOW;
    end else if (pct <= low_pct) begin
      mode_next = MODE_LOW;
    end else begin
      if (mode != MODE_NORMAL) begin
        disp_next     = DISP_ON;
        bl_set_next   = 1'b1;
        bl_level_next = full_bl;
        sw_next       = SW_RUN;
      end
      supply_next = 1'b1;
      mode_next   = MODE_NORMAL;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode            <= MODE_NORMAL;
      supply          <= 1'b1;
      percent         <= '0;
      battery_mode    <= MODE_NORMAL;
      display_cmd     <= DISP_NONE;
      stopwatch_cmd   <= SW_NONE;
      backlight_set   <= 1'b0;
      backlight_level <= '0;
      supply_on       <= 1'b1;
    end else if (cmd.commit) begin
      mode            <= mode_next;
      supply          <= supply_next;
      percent         <= pct;
      battery_mode    <= mode_next;
      display_cmd     <= disp_next;
      stopwatch_cmd   <= sw_next;
      backlight_set   <= bl_set_next;
      backlight_level <= bl_level_next;
      supply_on       <= supply_next;
    end
  end

`ifndef NO_ASSERTIONS
  a_level_zero: assert property (@(posedge clk) disable iff (rst)
    !backlight_set |-> backlight_level == '0)
    else $error("backlight level without set");
  a_step_open: assert property (@(posedge clk) disable iff (rst)
    cmd.step |-> lo < hi)
    else $error("search step on closed interval");
  a_empty_cut: assert property (@(posedge clk) disable iff (rst)
    cmd.commit && pct == '0 |=> !supply && !supply_on)
    else $error("empty battery left supply on");
  a_mode_sync: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |=> battery_mode == mode)
    else $error("reported mode differs from held mode");
`endif

endmodule

// File: rtl/bgpm_ctrl.sv
// Controller: sequences load, search steps, percent lookup and result transfer.
module bgpm_ctrl import bgpm_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  output logic     out_valid,
  input  logic     out_ready,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SEARCH,
    S_CALC,
    S_FINISH
  } state_t;

  state_t state;
  logic   out_free;

  assign in_ready   = (state == S_IDLE);
  assign out_free   = !out_valid || out_ready;
  assign cmd.load   = (state == S_IDLE) && in_valid;
  assign cmd.step   = (state == S_SEARCH) && !stat.search_done;
  assign cmd.calc   = (state == S_SEARCH) && stat.search_done;
  assign cmd.commit = (state == S_FINISH) && out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (cmd.commit) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
      unique case (state)
        S_IDLE:   if (in_valid) state <= S_SEARCH;
        S_SEARCH: if (stat.search_done) state <= S_CALC;
        S_CALC:   state <= S_FINISH;
        S_FINISH: if (out_free) state <= S_IDLE;
        default:  state <= S_IDLE;
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  a_one_cmd: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.load, cmd.step, cmd.calc, cmd.commit}))
    else $error("conflicting datapath commands");
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |-> !out_valid || out_ready)
    else $error("result overwritten before transfer");
  a_valid_after_commit: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |=> out_valid)
    else $error("commit without result valid");
`endif

endmodule

// File: rtl/battery_gauge_power_manager_unit.sv
// Battery gauge and power manager: one result per sample.
// Each sample is loaded, searched step by step, looked up and committed to the result;
// the binary search takes at most ceil(log2(depth+1)) steps (7 or 8 here).
// One sample is worked on at a time; next sample accepted while a result waits.
// Reset (rst, synchronous): mode normal, supply enabled, registers 15/5/50/100.
module battery_gauge_power_manager_unit import bgpm_pkg::*; #(
  parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
  parameter int ADC_BITS    = ADC_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  bgpm_in_if.sink               in_ch,
  bgpm_out_if.source            out_ch,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  bgpm_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  bgpm_datapath #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .ADC_BITS    (ADC_BITS)
  ) u_dp (
    .clk             (clk),
    .rst             (rst),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .adc_code        (in_ch.adc_code),
    .cmd             (cmd),
    .stat            (stat),
    .percent         (out_ch.percent),
    .battery_mode    (out_ch.battery_mode),
    .display_cmd     (out_ch.display_cmd),
    .stopwatch_cmd   (out_ch.stopwatch_cmd),
    .backlight_set   (out_ch.backlight_set),
    .backlight_level (out_ch.backlight_level),
    .supply_on       (out_ch.supply_on)
  );

endmodule
